@@ sv/ltpe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ltpe_pkg;

  // Width of every input field, of the result field and of the configuration data.
  localparam int FIELD_W = 32;

  // Bit counter of the serial engine; one pass walks all FIELD_W bits of its stream.
  localparam int CNT_W = $clog2(FIELD_W);

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHARE_MODULUS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MID_MODULUS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MODULUS    = 2'd3;

  // Register values after reset.
  localparam logic             RST_THRESHOLD_MODE = 1'b1;
  localparam logic [FIELD_W-1:0] RST_SHARE_MODULUS = 32'd2147483647;
  localparam logic [FIELD_W-1:0] RST_MID_MODULUS   = 32'd65536;
  localparam logic [FIELD_W-1:0] RST_OUT_MODULUS   = 32'd2;

  // Operations of the serial modular engine.
  typedef enum logic [1:0] {
    ENG_RED = 2'd0,  // remainder of the streamed word
    ENG_MUL = 2'd1,  // streamed word times operand, with quotient and remainder
    ENG_ADD = 2'd2   // add operand to the held remainder, one step
  } eng_kind_t;

  typedef struct packed {
    logic      start;
    eng_kind_t kind;
  } eng_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } eng_stat_t;

endpackage

`default_nettype wire

@@ sv/ltpe_mod_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ltpe_mod_engine #(
  parameter int MW = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ltpe_pkg::eng_cmd_t            cmd,
  input  logic [ltpe_pkg::FIELD_W-1:0]  stream,
  input  logic [MW-1:0]                 opnd,
  input  logic [MW-1:0]                 modulus,
  output ltpe_pkg::eng_stat_t           stat,
  output logic [MW-1:0]                 rem,
  output logic [ltpe_pkg::FIELD_W-1:0]  quo
);
  import ltpe_pkg::*;

  // The engine keeps value = q * m + r with r below m. Each step either doubles the
  // value (shifting in one stream bit for a reduction) or adds the operand, and each
  // step needs a single compare and subtract because the operand never exceeds m.

  eng_kind_t          kind, kind_next;
  logic               busy, busy_next;
  logic               done, done_next;
  logic               phase, phase_next;
  logic [FIELD_W-1:0] sreg, sreg_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [MW-1:0]      r, r_next;
  logic [FIELD_W-1:0] q, q_next;
  logic [MW-1:0]      a, a_next;
  logic [MW-1:0]      m, m_next;

  logic               in_bit;
  logic [MW:0]        dbl_t, add_t;
  logic               dbl_ge, add_ge;
  logic [MW-1:0]      dbl_r, add_r;
  logic               last_bit;
  logic               adv;

  assign in_bit   = (kind == ENG_RED) ? sreg[FIELD_W-1] : 1'b0;
  assign dbl_t    = {r, in_bit};
  assign dbl_ge   = (dbl_t >= {1'b0, m});
  assign dbl_r    = dbl_ge ? MW'(dbl_t - {1'b0, m}) : MW'(dbl_t);
  assign add_t    = {1'b0, r} + {1'b0, a};
  assign add_ge   = (add_t >= {1'b0, m});
  assign add_r    = add_ge ? MW'(add_t - {1'b0, m}) : MW'(add_t);
  assign last_bit = (cnt == CNT_W'(FIELD_W - 1));

  always_comb begin
    kind_next  = kind;
    busy_next  = busy;
    done_next  = 1'b0;
    phase_next = phase;
    sreg_next  = sreg;
    cnt_next   = cnt;
    r_next     = r;
    q_next     = q;
    a_next     = a;
    m_next     = m;
    adv        = 1'b0;
    if (cmd.start) begin
      busy_next  = 1'b1;
      kind_next  = cmd.kind;
      a_next     = opnd;
      m_next     = modulus;
      phase_next = 1'b0;
      if (cmd.kind != ENG_ADD) begin
        sreg_next = stream;
        cnt_next  = '0;
        r_next    = '0;
        q_next    = '0;
      end
    end else if (busy) begin
      unique case (kind)
        ENG_RED: begin
          r_next = dbl_r;
          q_next = {q[FIELD_W-2:0], dbl_ge};
          adv    = 1'b1;
        end
        ENG_MUL: begin
          if (!phase) begin
            r_next = dbl_r;
            q_next = {q[FIELD_W-2:0], dbl_ge};
            // A one bit of the multiplier costs an extra add step.
            if (sreg[FIELD_W-1]) begin
              phase_next = 1'b1;
            end else begin
              adv = 1'b1;
            end
          end else begin
            r_next     = add_r;
            q_next     = q + FIELD_W'(add_ge);
            phase_next = 1'b0;
            adv        = 1'b1;
          end
        end
        ENG_ADD: begin
          r_next    = add_r;
          q_next    = q + FIELD_W'(add_ge);
          busy_next = 1'b0;
          done_next = 1'b1;
        end
        default: begin
          busy_next = 1'b0;
        end
      endcase
      if (adv) begin
        sreg_next = sreg << 1;
        cnt_next  = cnt + 1'b1;
        if (last_bit) begin
          busy_next = 1'b0;
          done_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind  <= ENG_RED;
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
    end else begin
      kind  <= kind_next;
      busy  <= busy_next;
      done  <= done_next;
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    sreg <= sreg_next;
    cnt  <= cnt_next;
    r    <= r_next;
    q    <= q_next;
    a    <= a_next;
    m    <= m_next;
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign rem       = r;
  assign quo       = q;

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> busy)
    else $error("engine did not go busy after a start");

  a_rem_reduced: assert property (@(posedge clk) disable iff (rst)
    done |-> (r < m))
    else $error("engine finished with a remainder not below the modulus");

endmodule

`default_nettype wire

@@ sv/lwr_threshold_prf_eval.sv @@
// An element that does not end a share takes longer for each one bit of x_elem.
// Ending a direct evaluation adds a rounding that grows with popcount(out_modulus).
// Ending a threshold share adds a rounding that grows with popcount(mid_modulus) and a
// combination, the last share a final rounding that grows with popcount(out_modulus).
// Throughput: one transaction at a time; the input stalls until the previous one is done.
// Reset (synchronous): registers take their defaults, both sums clear, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module lwr_threshold_prf_eval #(
  parameter int MOD_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [ltpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ltpe_pkg::FIELD_W-1:0]    cfg_data,
  // Input channel.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ltpe_pkg::FIELD_W-1:0]    x_elem,
  input  logic [ltpe_pkg::FIELD_W-1:0]    key_elem,
  input  logic                            share_last,
  input  logic                            eval_last,
  // Output channel.
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ltpe_pkg::FIELD_W-1:0]    prf_value
);
  import ltpe_pkg::*;

  // Moduli hold only the low MOD_BITS bits of a 32-bit write.
  localparam int MW = (MOD_BITS < FIELD_W) ? MOD_BITS : FIELD_W;

  // The whole datapath is one serial modular engine. The sequencer below feeds it
  // one pass after another:
  //   1. reduce key_elem mod q (one bit per cycle),
  //   2. multiply x_elem by that residue mod q (an extra add step per one bit),
  //   3. reduce the running dot product mod q and add the product.
  // On the last element of a share the sum is rounded: reduce, multiply by the target
  // modulus, add half the source modulus, and keep the quotient. In threshold mode the
  // rounded share is then added to (first share) or subtracted from the combination
  // mod q1, and the last share rounds the combination from q1 to p.
  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_RKEY = 11'b000_0000_0010,
    S_MUL  = 11'b000_0000_0100,
    S_RDOT = 11'b000_0000_1000,
    S_ADOT = 11'b000_0001_0000,
    S_RRED = 11'b000_0010_0000,
    S_RMUL = 11'b000_0100_0000,
    S_RADD = 11'b000_1000_0000,
    S_RCMB = 11'b001_0000_0000,
    S_ACMB = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_t;

  state_t             state, state_next;

  // Configuration registers.
  logic               mode;
  logic [MW-1:0]      q_mod, q1_mod, p_mod;

  // Evaluation state.
  logic [MW-1:0]      dot, dot_next;
  logic [MW-1:0]      comb, comb_next;
  logic               first, first_next;

  // Held operands of the transaction in flight.
  logic [FIELD_W-1:0] x_hold;
  logic               s_hold, e_hold;
  logic [MW-1:0]      prod, prod_next;
  logic [MW-1:0]      part_op, part_next;
  logic               rnd_mid, rnd_mid_next;
  logic               rnd_final, rnd_final_next;

  // Engine connections.
  eng_cmd_t           eng_cmd;
  eng_stat_t          eng_stat;
  logic [FIELD_W-1:0] eng_stream;
  logic [MW-1:0]      eng_opnd, eng_mod;
  logic [MW-1:0]      eng_rem;
  logic [FIELD_W-1:0] eng_quo;

  logic [MW-1:0]      qn, q1n, rnd_m, rnd_p;
  logic               in_take, out_take, load_out;

  // A modulus of zero behaves as one, so every residue is zero.
  assign qn  = (q_mod == '0) ? MW'(1) : q_mod;
  assign q1n = (q1_mod == '0) ? MW'(1) : q1_mod;

  // A rounding goes from q to p (direct), from q to q1 (a threshold share) or from
  // q1 to p (the threshold combination).
  assign rnd_m = rnd_mid ? q1n : qn;
  assign rnd_p = rnd_final ? p_mod : q1n;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  always_comb begin
    state_next     = state;
    eng_cmd.start  = 1'b0;
    eng_cmd.kind   = ENG_RED;
    eng_stream     = '0;
    eng_opnd       = '0;
    eng_mod        = qn;
    dot_next       = dot;
    comb_next      = comb;
    first_next     = first;
    prod_next      = prod;
    part_next      = part_op;
    rnd_mid_next   = rnd_mid;
    rnd_final_next = rnd_final;
    load_out       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          eng_cmd.start = 1'b1;
          eng_cmd.kind  = ENG_RED;
          eng_stream    = key_elem;
          state_next    = S_RKEY;
        end
      end
      S_RKEY: begin
        // Only one factor needs reducing; the other is streamed as multiplier bits.
        if (eng_stat.done) begin
          eng_cmd.start = 1'b1;
          eng_cmd.kind  = ENG_MUL;
          eng_stream    = x_hold;
          eng_opnd      = eng_rem;
          state_next    = S_MUL;
        end
      end
      S_MUL: begin
        // The dot product is reduced again in case q was changed between transactions.
        if (eng_stat.done) begin
          prod_next     = eng_rem;
          eng_cmd.start = 1'b1;
          eng_cmd.kind  = ENG_RED;
          eng_stream    = FIELD_W'(dot);
          state_next    = S_RDOT;
        end
      end
      S_RDOT: begin
        if (eng_stat.done) begin
          eng_cmd.start = 1'b1;
          eng_cmd.kind  = ENG_ADD;
          eng_opnd      = prod;
          state_next    = S_ADOT;
        end
      end
      S_ADOT: begin
        if (eng_stat.done) begin
          if (!s_hold) begin
            dot_next   = eng_rem;
            state_next = S_IDLE;
          end else begin
            // End of a share: clear the dot product and round its final value.
            dot_next       = '0;
            eng_cmd.start  = 1'b1;
            eng_cmd.kind   = ENG_RED;
            eng_stream     = FIELD_W'(eng_rem);
            rnd_mid_next   = 1'b0;
            rnd_final_next = !mode;
            state_next     = S_RRED;
          end
        end
      end
      S_RRED: begin
        if (eng_stat.done) begin
          eng_cmd.start = 1'b1;
          eng_cmd.kind  = ENG_MUL;
          eng_stream    = FIELD_W'(rnd_p);
          eng_opnd      = eng_rem;
          eng_mod       = rnd_m;
          state_next    = S_RMUL;
        end
      end
      S_RMUL: begin
        // Adding half the modulus turns the floor of the quotient into rounding.
        if (eng_stat.done) begin
          eng_cmd.start = 1'b1;
          eng_cmd.kind  = ENG_ADD;
          eng_opnd      = rnd_m >> 1;
          eng_mod       = rnd_m;
          state_next    = S_RADD;
        end
      end
      S_RADD: begin
        if (eng_stat.done) begin
          if (rnd_final) begin
            comb_next  = '0;
            first_next = 1'b1;
            if (!out_valid || out_take) begin
              load_out   = 1'b1;
              state_next = S_IDLE;
            end else begin
              state_next = S_OUT;
            end
          end else begin
            // The rounded share is at most q1, so it serves as an add operand as is.
            // A later share is subtracted by adding q1 minus the share, which also
            // handles a share that rounded up to q1 itself.
            part_next     = first ? eng_quo[MW-1:0] : q1n - eng_quo[MW-1:0];
            eng_cmd.start = 1'b1;
            eng_cmd.kind  = ENG_RED;
            eng_stream    = FIELD_W'(comb);
            eng_mod       = q1n;
            state_next    = S_RCMB;
          end
        end
      end
      S_RCMB: begin
        if (eng_stat.done) begin
          eng_cmd.start = 1'b1;
          eng_cmd.kind  = ENG_ADD;
          eng_opnd      = part_op;
          eng_mod       = q1n;
          state_next    = S_ACMB;
        end
      end
      S_ACMB: begin
        if (eng_stat.done) begin
          comb_next  = eng_rem;
          first_next = 1'b0;
          if (e_hold) begin
            eng_cmd.start  = 1'b1;
            eng_cmd.kind   = ENG_RED;
            eng_stream     = FIELD_W'(eng_rem);
            eng_mod        = q1n;
            rnd_mid_next   = 1'b1;
            rnd_final_next = 1'b1;
            state_next     = S_RRED;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_OUT: begin
        // The engine holds the result until the output register frees up.
        if (out_take) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  ltpe_mod_engine #(
    .MW(MW)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .cmd     (eng_cmd),
    .stream  (eng_stream),
    .opnd    (eng_opnd),
    .modulus (eng_mod),
    .stat    (eng_stat),
    .rem     (eng_rem),
    .quo     (eng_quo)
  );

  // Config registers; write only while the block is idle, which it does not check.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= RST_THRESHOLD_MODE;
      q_mod  <= RST_SHARE_MODULUS[MW-1:0];
      q1_mod <= RST_MID_MODULUS[MW-1:0];
      p_mod  <= RST_OUT_MODULUS[MW-1:0];
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD_MODE: mode   <= cfg_data[0];
        CFG_SHARE_MODULUS:  q_mod  <= cfg_data[MW-1:0];
        CFG_MID_MODULUS:    q1_mod <= cfg_data[MW-1:0];
        CFG_OUT_MODULUS:    p_mod  <= cfg_data[MW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and evaluation state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dot   <= '0;
      comb  <= '0;
      first <= 1'b1;
    end else begin
      state <= state_next;
      dot   <= dot_next;
      comb  <= comb_next;
      first <= first_next;
    end
  end

  // Operands of the transaction in flight.
  always_ff @(posedge clk) begin
    if (in_take) begin
      x_hold <= x_elem;
      s_hold <= share_last;
      e_hold <= eval_last;
    end
    prod      <= prod_next;
    part_op   <= part_next;
    rnd_mid   <= rnd_mid_next;
    rnd_final <= rnd_final_next;
  end

  // Output register: a finished result waits here while the next transaction starts.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      prf_value <= eng_quo;
    end
  end

  a_idle_engine_free: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> (!eng_stat.busy && !eng_stat.done))
    else $error("input taken while the engine is still working");

  a_out_from_round: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RADD || state == S_OUT))
    else $error("result loaded outside the final rounding");

  a_wait_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> out_valid)
    else $error("waiting for the output slot while it is empty");

endmodule

`default_nettype wire

@@ test/prf_value_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels and the register port of the PRF evaluator, keeps its
// own copy of the registers and the running sums, and compares every output
// transaction with the oldest predicted value.
module prf_value_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ltpe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ltpe_pkg::FIELD_W-1:0]  cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [ltpe_pkg::FIELD_W-1:0]  x_elem,
  input  logic [ltpe_pkg::FIELD_W-1:0]  key_elem,
  input  logic                          share_last,
  input  logic                          eval_last,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [ltpe_pkg::FIELD_W-1:0]  prf_value,
  output int                            fail_count,
  output int                            waiting,
  output int                            results_seen
);
  import ltpe_pkg::*;

  bit        mode_thr;
  bit [63:0] q_reg, q1_reg, p_reg;
  bit [63:0] dot_sum, comb_sum;
  bit        first_flag;
  bit [31:0] prf_expected[$];

  // floor((v*to + floor(from/2)) / from) with v reduced mod from; a zero modulus acts as 1.
  function automatic bit [63:0] rescale(bit [63:0] v, bit [63:0] from_mod, bit [63:0] to_mod);
    bit [63:0] m;
    m = (from_mod == 0) ? 64'd1 : from_mod;
    return ((v % m) * to_mod + (m >> 1)) / m;
  endfunction

  function automatic void absorb_element(bit [31:0] x, bit [31:0] k, bit s_last, bit e_last);
    bit [63:0] q, q1, prod, part, acc, r;
    q  = (q_reg == 0) ? 64'd1 : q_reg;
    q1 = (q1_reg == 0) ? 64'd1 : q1_reg;
    prod = ((x % q) * (k % q)) % q;
    dot_sum = ((dot_sum % q) + prod) % q;
    if (!s_last) return;
    if (!mode_thr) begin
      r = rescale(dot_sum, q, p_reg);
      prf_expected = {prf_expected, r[31:0]};
      dot_sum = 0;
      comb_sum = 0;
      first_flag = 1'b1;
      return;
    end
    part = rescale(dot_sum, q, q1) % q1;
    acc = comb_sum % q1;
    if (first_flag) acc = (acc + part) % q1;
    else            acc = (acc + (q1 - part)) % q1;
    comb_sum = acc;
    dot_sum = 0;
    first_flag = 1'b0;
    if (!e_last) return;
    r = rescale(comb_sum, q1, p_reg);
    prf_expected = {prf_expected, r[31:0]};
    comb_sum = 0;
    first_flag = 1'b1;
  endfunction

  always @(posedge clk) begin
    bit [31:0] want;
    if (rst) begin
      mode_thr = RST_THRESHOLD_MODE;
      q_reg = RST_SHARE_MODULUS;
      q1_reg = RST_MID_MODULUS;
      p_reg = RST_OUT_MODULUS;
      dot_sum = 0;
      comb_sum = 0;
      first_flag = 1'b1;
      fail_count = 0;
      results_seen = 0;
      prf_expected.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESHOLD_MODE: mode_thr = cfg_data[0];
          CFG_SHARE_MODULUS:  q_reg = cfg_data;
          CFG_MID_MODULUS:    q1_reg = cfg_data;
          CFG_OUT_MODULUS:    p_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (prf_expected.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("prf_value %0d arrived with no result expected", prf_value);
        end else begin
          want = prf_expected.pop_front();
          if (want !== prf_value) begin
            fail_count++;
            if (fail_count <= 10)
              $display("prf_value mismatch on result %0d: expected %0d, got %0d",
                       results_seen, want, prf_value);
          end
        end
      end
      if (in_valid && !in_stall)
        absorb_element(x_elem, key_elem, share_last, eval_last);
    end
    waiting = prf_expected.size();
  end

endmodule

@@ test/tb_lwr_threshold_prf_eval.sv @@
`timescale 1ns / 1ps

// Top of the PRF evaluator bench. It only produces stimulus and gives the
// verdict; prediction and comparison live in prf_value_checker.
module tb_lwr_threshold_prf_eval;
  import ltpe_pkg::*;

  // Cycles the block may still spend on an element that produces no result
  // (element, share rounding and combination, with margin).
  localparam int SETTLE_CYCLES = 400;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 173;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FIELD_W-1:0]   cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [FIELD_W-1:0]   x_elem;
  logic [FIELD_W-1:0]   key_elem;
  logic                 share_last;
  logic                 eval_last;
  logic                 out_valid;
  logic                 out_stall;
  logic [FIELD_W-1:0]   prf_value;

  int        fail_count, waiting, results_seen;
  int        items_sent, settings_used;
  int        send_idle_pct, recv_idle_pct;
  bit        quiet;
  bit [31:0] cur_q;

  lwr_threshold_prf_eval dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .x_elem(x_elem), .key_elem(key_elem), .share_last(share_last), .eval_last(eval_last),
    .out_valid(out_valid), .out_stall(out_stall), .prf_value(prf_value)
  );

  prf_value_checker checker_i (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .x_elem(x_elem), .key_elem(key_elem), .share_last(share_last), .eval_last(eval_last),
    .out_valid(out_valid), .out_stall(out_stall), .prf_value(prf_value),
    .fail_count(fail_count), .waiting(waiting), .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog. It allows several times the slowest case with every stall at its longest.
  initial begin
    #16_000_000;
    $display("Verification failed");
    $finish;
  end

  // Receiver side: random stall bursts of random length, at a density set per
  // phase, and none at all once the final quiet stretch begins.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst && !quiet && $urandom_range(0, 99) < recv_idle_pct) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Element values aimed at the interesting spots of the current share modulus:
  // zero, all ones, just below q, exactly q, residues and raw 32-bit noise.
  function automatic bit [31:0] pick_elem();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return cur_q - 1;
      3:       return cur_q;
      4, 5, 6: return (cur_q == 0) ? $urandom : $urandom % cur_q;
      default: return $urandom;
    endcase
  endfunction

  // Modulus values, extremes included. Zero and one lie outside the normal
  // range but the register takes them, so they are exercised too.
  function automatic bit [31:0] pick_modulus();
    case ($urandom_range(0, 11))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'd2;
      3:       return 32'd3;
      4:       return 32'hFFFF_FFFF;
      5:       return 32'd2147483647;
      6:       return 32'd65536;
      7, 8, 9: return $urandom_range(2, 1000);
      default: return $urandom;
    endcase
  endfunction

  // Present one transaction and hold it until accepted. Valid stays high on
  // return so that back-to-back transactions carry no forced gap; every caller
  // that lets time pass afterwards lowers it first.
  task automatic send_element(input bit [31:0] x, input bit [31:0] k, input bit sl,
                              input bit el);
    if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid = 1'b1;
    x_elem = x;
    key_elem = k;
    share_last = sl;
    eval_last = el;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  // Stop sending and wait for every predicted result to be delivered.
  task automatic drain();
    in_valid = 1'b0;
    while (waiting != 0) @(negedge clk);
  endtask

  // Full quiescence: results delivered, then room for a trailing element that
  // produces no result to finish inside the block.
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [31:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_SHARE_MODULUS) cur_q = data;
  endtask

  task automatic apply_settings(input bit mode, input bit [31:0] q, input bit [31:0] q1,
                                input bit [31:0] p);
    write_reg(CFG_THRESHOLD_MODE, {31'b0, mode});
    write_reg(CFG_SHARE_MODULUS, q);
    write_reg(CFG_MID_MODULUS, q1);
    write_reg(CFG_OUT_MODULUS, p);
    settings_used++;
  endtask

  // Mostly well-formed evaluations (1 to 4 shares of 1 to 6 elements) with
  // random content, mixed with stray elements carrying random end markers.
  // Occasionally the sender holds off until the pipeline of results is empty.
  task automatic run_phase(input int n_items);
    int done_items, shares, len, s, e;
    bit sl, el;
    done_items = 0;
    while (done_items < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_element(pick_elem(), pick_elem(), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
        done_items++;
      end else begin
        shares = $urandom_range(1, 4);
        for (s = 0; s < shares; s++) begin
          len = $urandom_range(1, 6);
          for (e = 0; e < len; e++) begin
            sl = (e == len - 1);
            // eval_last on an inner element must be ignored by the block.
            el = sl ? (s == shares - 1) : 1'($urandom_range(0, 1));
            send_element(pick_elem(), pick_elem(), sl, el);
            done_items++;
            if ($urandom_range(0, 49) == 0) drain();
          end
        end
      end
    end
    // Sometimes leave a share open so the next setting starts mid-stream.
    if ($urandom_range(0, 1) != 0) send_element(pick_elem(), pick_elem(), 1'b0, 1'b0);
  endtask

  initial begin
    int ph;
    bit mode;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_THRESHOLD_MODE;
    cfg_data = '0;
    in_valid = 1'b0;
    x_elem = '0;
    key_elem = '0;
    share_last = 1'b0;
    eval_last = 1'b0;
    quiet = 1'b0;
    send_idle_pct = 30;
    recv_idle_pct = 30;
    items_sent = 0;
    settings_used = 0;
    cur_q = RST_SHARE_MODULUS;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, reset settings: a three-share threshold evaluation with
    // out-of-range elements, an element equal to q, and an eval_last that
    // arrives without share_last; then a single-share evaluation of zeros.
    send_element(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_element(32'd5, 32'd7, 1'b1, 1'b0);
    send_element(32'd0, 32'd0, 1'b0, 1'b1);
    send_element(32'h7FFF_FFFE, 32'h7FFF_FFFE, 1'b1, 1'b0);
    send_element(32'd12345, 32'h7FFF_FFFF, 1'b1, 1'b1);
    send_element(32'd0, 32'd0, 1'b1, 1'b1);

    // Direct mode at the widest moduli; a result is due on every share end,
    // whatever eval_last says.
    settle();
    apply_settings(1'b0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_element(32'hFFFF_FFFE, 32'hFFFF_FFFE, 1'b0, 1'b0);
    send_element(32'hFFFF_FFFF, 32'd1, 1'b1, 1'b0);
    send_element(32'd3, 32'd5, 1'b1, 1'b1);

    // Zero output modulus: the rounding must give zero.
    settle();
    apply_settings(1'b0, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_element(32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b0);

    // Zero share and mid moduli: every residue collapses to zero.
    settle();
    apply_settings(1'b1, 32'd0, 32'd0, 32'd1);
    send_element(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);

    // Smallest moduli, two shares combined, then a share left open across a
    // register change so the kept sum is reduced by the new modulus.
    settle();
    apply_settings(1'b1, 32'd2, 32'd2, 32'd1);
    send_element(32'd1, 32'd1, 1'b1, 1'b0);
    send_element(32'd1, 32'd1, 1'b1, 1'b0);
    send_element(32'd3, 32'd3, 1'b0, 1'b0);
    settle();
    apply_settings(1'b1, 32'd1000003, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_element(32'd999999, 32'd123, 1'b1, 1'b1);
    send_element(32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1);

    // Random part. The first two settings pin one of each mode; idle density
    // varies per phase, including phases with none, and the last phase runs
    // with no idling on either side.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      mode = (ph == 0) ? 1'b0 : (ph == 1) ? 1'b1 : 1'($urandom_range(0, 1));
      apply_settings(mode, pick_modulus(), pick_modulus(), pick_modulus());
      case (ph % 3)
        0: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        1: begin
          send_idle_pct = 25;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 60;
          recv_idle_pct = 60;
        end
      endcase
      if (ph == RANDOM_PHASES - 1) quiet = 1'b1;
      run_phase(PHASE_ITEMS);
    end

    settle();
    $display("Sent %0d transactions under %0d register settings,", items_sent, settings_used);
    $display("both modes, zero and extreme moduli; compared %0d PRF values, %0d mismatches.",
             results_seen, fail_count);
    if (fail_count == 0 && waiting == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
